// ===== src/dexdi_pkg.sv =====
// Shared types, opcode and record codes, and helpers for the debug-info interpreter.
package dexdi_pkg;

    localparam int MAX_REGISTERS_DEF = 256;

    // Debug-info opcodes
    localparam logic [7:0] OP_END_SEQUENCE   = 8'h00;
    localparam logic [7:0] OP_ADVANCE_PC     = 8'h01;
    localparam logic [7:0] OP_ADVANCE_LINE   = 8'h02;
    localparam logic [7:0] OP_START_LOCAL    = 8'h03;
    localparam logic [7:0] OP_START_LOCAL_EX = 8'h04;
    localparam logic [7:0] OP_END_LOCAL      = 8'h05;
    localparam logic [7:0] OP_RESTART_LOCAL  = 8'h06;
    localparam logic [7:0] OP_PROLOGUE_END   = 8'h07;
    localparam logic [7:0] OP_EPILOGUE_BEGIN = 8'h08;
    localparam logic [7:0] OP_SET_FILE       = 8'h09;
    localparam logic [7:0] OP_SPECIAL_BASE   = 8'h0a;

    // Special opcode line/address split
    localparam int LINE_RANGE = 15;
    localparam int LINE_BASE  = -4;
    // floor(x / 15) == (x * 137) >> 11 for every x below 256
    localparam int DIV15_MUL   = 137;
    localparam int DIV15_SHIFT = 11;

    // Record kinds
    localparam logic [1:0] REC_POSITION = 2'd0;
    localparam logic [1:0] REC_CLOSED   = 2'd1;
    localparam logic [1:0] REC_END      = 2'd2;
    localparam logic [1:0] REC_BAD_REG  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_REG_COUNT   = 2'd0;
    localparam logic [1:0] CFG_LINE_START  = 2'd1;
    localparam logic [1:0] CFG_SOURCE_START = 2'd2;

    localparam logic [8:0] REG_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [15:0]        reg_operand;
        logic [31:0]        name_index;
        logic [31:0]        type_index;
        logic [31:0]        signature_index;
        logic [31:0]        addr_advance;
        logic signed [31:0] line_advance;
        logic [31:0]        source_index;
    } item_t;

    typedef struct packed {
        logic [31:0] start_address;
        logic [31:0] local_name;
        logic [31:0] local_type;
        logic [31:0] local_signature;
        logic        has_signature;
    } row_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] address;
        logic [31:0] line;
        logic [31:0] src_file;
        logic [7:0]  local_register;
        logic [31:0] start_address;
        logic [31:0] local_name;
        logic [31:0] local_type;
        logic [31:0] local_signature;
        logic        has_signature;
    } rec_t;

    typedef struct packed {
        logic        en;
        row_t        row;
    } tab_wr_t;

    typedef struct packed {
        logic [31:0] base_line;
        logic [31:0] source_start;
        logic        ld_line;
        logic        ld_source;
        logic [31:0] wdata;
    } cfg_t;

    // Returns {quotient[4:0], remainder[3:0]} of adj / 15
    function automatic logic [8:0] div15(input logic [7:0] adj);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  qm;
        logic [7:0]  rm;
        prod = 16'(adj) * 16'(DIV15_MUL);
        q    = prod[DIV15_SHIFT+4:DIV15_SHIFT];
        qm   = 8'(q) * 8'(LINE_RANGE);
        rm   = adj - qm;
        return {q, rm[3:0]};
    endfunction

endpackage

// ===== src/dexdi_table.sv =====
// Per-register locals table: row memory, written flags and write-to-read bypass.
module dexdi_table
    import dexdi_pkg::*;
#(
    parameter int MAX_REGISTERS = MAX_REGISTERS_DEF,
    localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output row_t             rd_row,
    input  tab_wr_t          wr,
    input  logic [IDX_W-1:0] wr_addr
);

    row_t               row_mem [MAX_REGISTERS];
    logic [MAX_REGISTERS-1:0] written_reg;
    row_t               rd_row_reg;
    row_t               fwd_row_reg;
    logic               rd_written_reg;
    logic               hit_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg  <= row_mem[rd_addr];
            fwd_row_reg <= wr.row;
        end
        if (wr.en)
        begin
            row_mem[wr_addr] <= wr.row;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
                hit_reg        <= wr.en && (wr_addr == rd_addr);
            end
            if (wr.en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_row = hit_reg ? fwd_row_reg : (rd_written_reg ? rd_row_reg : '0);

endmodule

// ===== src/dexdi_exec.sv =====
// Opcode execution: position state, live bits, record build and table update.
module dexdi_exec
    import dexdi_pkg::*;
#(
    parameter int MAX_REGISTERS = MAX_REGISTERS_DEF,
    localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  item_t            item,
    input  row_t             row_in,
    input  cfg_t             cfg,
    input  logic [8:0]       reg_count,
    output logic             rec_valid,
    output rec_t             rec,
    output tab_wr_t          tab_wr,
    output logic [IDX_W-1:0] tab_addr
);

    logic [31:0]              cur_address_reg, cur_address_next;
    logic [31:0]              cur_line_reg, cur_line_next;
    logic [31:0]              cur_source_reg, cur_source_next;
    logic [MAX_REGISTERS-1:0] live_reg, live_next;

    logic [31:0]              step_address, step_line, step_source;
    logic [MAX_REGISTERS-1:0] step_live;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     is_local;
    logic                     live_bit;
    logic                     reinit;
    logic [7:0]               adj;
    logic [8:0]               qr;
    rec_t                     closed_rec;

    assign idx      = item.reg_operand[IDX_W-1:0];
    assign tab_addr = idx;
    assign in_range = ({1'b0, item.reg_operand} < {8'b0, reg_count})
                   && ({1'b0, item.reg_operand} < 17'(MAX_REGISTERS));
    assign is_local = (item.opcode >= OP_START_LOCAL) && (item.opcode <= OP_RESTART_LOCAL);
    assign live_bit = live_reg[idx];
    assign adj      = item.opcode - OP_SPECIAL_BASE;
    assign qr       = div15(adj);

    always_comb
    begin
        closed_rec                 = '0;
        closed_rec.record_kind     = REC_CLOSED;
        closed_rec.address         = cur_address_reg;
        closed_rec.line            = cur_line_reg;
        closed_rec.src_file        = cur_source_reg;
        closed_rec.local_register  = item.reg_operand[7:0];
        closed_rec.start_address   = row_in.start_address;
        closed_rec.local_name      = row_in.local_name;
        closed_rec.local_type      = row_in.local_type;
        closed_rec.local_signature = row_in.local_signature;
        closed_rec.has_signature   = row_in.has_signature;
    end

    always_comb
    begin
        step_address = cur_address_reg;
        step_line    = cur_line_reg;
        step_source  = cur_source_reg;
        step_live    = live_reg;
        reinit       = 1'b0;
        rec_valid    = 1'b0;
        rec          = '0;
        tab_wr       = '0;

        if (is_local && !in_range)
        begin
            rec_valid          = 1'b1;
            rec.record_kind    = REC_BAD_REG;
            rec.address        = cur_address_reg;
            rec.line           = cur_line_reg;
            rec.src_file       = cur_source_reg;
            rec.local_register = item.reg_operand[7:0];
            reinit             = 1'b1;
        end
        else
        begin
            case (item.opcode)
                OP_END_SEQUENCE:
                begin
                    rec_valid       = 1'b1;
                    rec.record_kind = REC_END;
                    rec.address     = cur_address_reg;
                    rec.line        = cur_line_reg;
                    rec.src_file    = cur_source_reg;
                    reinit          = 1'b1;
                end
                OP_ADVANCE_PC:
                begin
                    step_address = cur_address_reg + item.addr_advance;
                end
                OP_ADVANCE_LINE:
                begin
                    step_line = cur_line_reg + item.line_advance;
                end
                OP_START_LOCAL, OP_START_LOCAL_EX:
                begin
                    if (live_bit)
                    begin
                        rec_valid = 1'b1;
                        rec       = closed_rec;
                    end
                    tab_wr.en                = 1'b1;
                    tab_wr.row.start_address = cur_address_reg;
                    tab_wr.row.local_name    = item.name_index - 32'd1;
                    tab_wr.row.local_type    = item.type_index - 32'd1;
                    if (item.opcode == OP_START_LOCAL_EX)
                    begin
                        tab_wr.row.local_signature = item.signature_index - 32'd1;
                        tab_wr.row.has_signature   = 1'b1;
                    end
                    step_live[idx] = 1'b1;
                end
                OP_END_LOCAL:
                begin
                    if (live_bit)
                    begin
                        rec_valid = 1'b1;
                        rec       = closed_rec;
                    end
                    step_live[idx] = 1'b0;
                end
                OP_RESTART_LOCAL:
                begin
                    // a dead local keeps its old name/type/signature
                    if (!live_bit)
                    begin
                        tab_wr.en                = 1'b1;
                        tab_wr.row               = row_in;
                        tab_wr.row.start_address = cur_address_reg;
                        step_live[idx]           = 1'b1;
                    end
                end
                OP_PROLOGUE_END, OP_EPILOGUE_BEGIN:
                begin
                end
                OP_SET_FILE:
                begin
                    step_source = item.source_index - 32'd1;
                end
                default:
                begin
                    step_address    = cur_address_reg + {27'b0, qr[8:4]};
                    step_line       = cur_line_reg + {28'b0, qr[3:0]} + 32'(LINE_BASE);
                    rec_valid       = 1'b1;
                    rec.record_kind = REC_POSITION;
                    rec.address     = step_address;
                    rec.line        = step_line;
                    rec.src_file    = cur_source_reg;
                end
            endcase
        end

        if (reinit)
        begin
            step_address = '0;
            step_line    = cfg.base_line;
            step_source  = cfg.source_start;
            step_live    = '0;
        end

        if (!fire)
        begin
            tab_wr.en = 1'b0;
        end
    end

    always_comb
    begin
        cur_address_next = fire ? step_address : cur_address_reg;
        cur_line_next    = fire ? step_line : cur_line_reg;
        cur_source_next  = fire ? step_source : cur_source_reg;
        live_next        = fire ? step_live : live_reg;
        // header writes take effect at once
        if (cfg.ld_line)
        begin
            cur_line_next = cfg.wdata;
        end
        if (cfg.ld_source)
        begin
            cur_source_next = cfg.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_address_reg <= '0;
            cur_line_reg    <= '0;
            cur_source_reg  <= '0;
            live_reg        <= '0;
        end
        else
        begin
            cur_address_reg <= cur_address_next;
            cur_line_reg    <= cur_line_next;
            cur_source_reg  <= cur_source_next;
            live_reg        <= live_next;
        end
    end

    a_reinit_clears_live: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rec_valid && (rec.record_kind == REC_END || rec.record_kind == REC_BAD_REG)
        |=> live_reg == '0)
        else $error("live bits not cleared after end or error record");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        tab_wr.en |-> in_range && fire)
        else $error("table written for an out-of-range register");

    a_closed_was_live: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rec_valid && rec.record_kind == REC_CLOSED |-> live_reg[idx])
        else $error("closed-local record for a dead register");

endmodule

// ===== src/dex_debug_info_interpreter.sv =====
// Top level of the debug-info interpreter: config registers, input stage, result register.
//
//  channel   | dir | transfer condition              | payload
//  ----------+-----+---------------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid & s_axis_tready   | tuser opcode, tdata operands
//  m_axis    | out | m_axis_tvalid & m_axis_tready   | tuser record kind, tdata record
//  cfg       | in  | cfg_we                          | cfg_addr index, cfg_wdata value
//
// One opcode per cycle sustained while m_axis is not back-pressured. At the input transfer
// edge the item is registered into the input stage and the locals table row
// of reg_operand is read (registered memory read), with a bypass for a row written by
// the item executing at that same edge.
// The execute stage then runs the opcode against that row and the position state, and
// any result is loaded into the output register at the edge on which that stage fires.
// Reset clears position state, live bits and the table written flags at once; no sweep.
// A stalled output register holds the execute stage, which then holds the input side.
module dex_debug_info_interpreter
    import dexdi_pkg::*;
#(
    parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] reg_operand, [47:16] name_index, [79:48] type_index,
    // [111:80] signature_index, [143:112] addr_advance, [175:144] line_advance,
    // [207:176] source_index
    input  logic [207:0] s_axis_tdata,
    // [7:0] opcode
    input  logic [7:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] address, [63:32] line, [95:64] src_file, [103:96] local_register,
    // [135:104] start_address, [167:136] local_name, [199:168] local_type,
    // [231:200] local_signature, [232] has_signature, [239:233] zero
    output logic [239:0] m_axis_tdata,
    // [1:0] record_kind
    output logic [1:0]   m_axis_tuser,

    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int IDX_W = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

    logic [8:0]  reg_count_reg;
    logic [31:0] base_line_reg;
    logic [31:0] source_start_reg;

    item_t       in_item;
    item_t       s1_item_reg;
    logic        s1_valid_reg;
    logic        s1_fire;
    logic        in_xfer;

    rec_t        out_rec_reg;
    logic        out_valid_reg;

    row_t             row;
    tab_wr_t          tab_wr;
    logic [IDX_W-1:0] tab_addr;
    rec_t             rec;
    logic             rec_valid;
    cfg_t             cfg;

    // unpack the input transfer
    always_comb
    begin
        in_item.opcode          = s_axis_tuser;
        in_item.reg_operand     = s_axis_tdata[15:0];
        in_item.name_index      = s_axis_tdata[47:16];
        in_item.type_index      = s_axis_tdata[79:48];
        in_item.signature_index = s_axis_tdata[111:80];
        in_item.addr_advance    = s_axis_tdata[143:112];
        in_item.line_advance    = s_axis_tdata[175:144];
        in_item.source_index    = s_axis_tdata[207:176];
    end

    // execute stage moves whenever the result register is free or draining
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_count_reg    <= REG_COUNT_RESET;
            base_line_reg    <= '0;
            source_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_REG_COUNT:    reg_count_reg    <= cfg_wdata[8:0];
                CFG_LINE_START:   base_line_reg    <= cfg_wdata;
                CFG_SOURCE_START: source_start_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.base_line    = base_line_reg;
        cfg.source_start = source_start_reg;
        cfg.ld_line      = cfg_we && (cfg_addr == CFG_LINE_START);
        cfg.ld_source    = cfg_we && (cfg_addr == CFG_SOURCE_START);
        cfg.wdata        = cfg_wdata;
    end

    // input stage
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    dexdi_table #(
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_addr (in_item.reg_operand[IDX_W-1:0]),
        .rd_row  (row),
        .wr      (tab_wr),
        .wr_addr (tab_addr)
    );

    dexdi_exec #(
        .MAX_REGISTERS (MAX_REGISTERS)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .item      (s1_item_reg),
        .row_in    (row),
        .cfg       (cfg),
        .reg_count (reg_count_reg),
        .rec_valid (rec_valid),
        .rec       (rec),
        .tab_wr    (tab_wr),
        .tab_addr  (tab_addr)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && rec_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.record_kind;
    assign m_axis_tdata  = {7'b0,
                            out_rec_reg.has_signature,
                            out_rec_reg.local_signature,
                            out_rec_reg.local_type,
                            out_rec_reg.local_name,
                            out_rec_reg.start_address,
                            out_rec_reg.local_register,
                            out_rec_reg.src_file,
                            out_rec_reg.line,
                            out_rec_reg.address};

endmodule
